@@ src/pofc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pofc_pkg
// Shared types and constants for the page offset floor cache.
// ----------------------------------------------------------------------------
package pofc_pkg;

  localparam int KIND_W  = 2;
  localparam int HASH_W  = 32;
  localparam int PAGE_W  = 16;
  localparam int OFF_W   = 32;
  localparam int STAMP_W = 32;

  // operation codes carried in the kind field; the fourth code is a no-op
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STAMP_W-1:0] STAMP_FIRST = 32'd1;
  localparam logic [STAMP_W-1:0] STAMP_LAST  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [PAGE_W-1:0]  page;
    logic [OFF_W-1:0]   offset;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctl_t;

  typedef struct packed {
    logic init;
    logic step;
    logic is_store;
  } cmp_ctl_t;

endpackage

@@ src/page_offset_floor_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_offset_floor_cache
// Fully associative page-to-offset table with floor lookup, stamp-ordered
// replacement on store, and whole-table clear.
// ----------------------------------------------------------------------------
// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------------------
// input   | in_valid / in_ready  | kind, path_hash, page_number, byte_offset
// output  | out_valid / out_ready| hit, found_page, found_offset
//
// Lookup: ST_SCAN reads the table one entry per cycle through the single read
// port, ST_LAST folds the last read, and ST_RESP loads the result; a new
// transaction is taken only back in ST_IDLE. Store: ST_WRITE writes the table
// before ST_RESP. Clear and the unused kind: ST_IDLE goes straight to ST_RESP.
// in_ready is high only while idle; a result waits in the output register while
// the next transaction runs, whose result stalls until that register is taken.
// Synchronous reset empties the table and sets the stamp counter to 1.
// ----------------------------------------------------------------------------
module page_offset_floor_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pofc_pkg::KIND_W-1:0]   kind,
  input  logic [pofc_pkg::HASH_W-1:0]   path_hash,
  input  logic [pofc_pkg::PAGE_W-1:0]   page_number,
  input  logic [pofc_pkg::OFF_W-1:0]    byte_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [pofc_pkg::PAGE_W-1:0]   found_page,
  output logic [pofc_pkg::OFF_W-1:0]    found_offset
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [pofc_pkg::HASH_W-1:0]  op_hash;
  logic [pofc_pkg::PAGE_W-1:0]  op_page;
  logic [pofc_pkg::OFF_W-1:0]   op_offset;

  pofc_pkg::mem_ctl_t           mem_ctl;
  pofc_pkg::cmp_ctl_t           cmp_ctl;
  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             ent_idx;
  logic [IDX_W-1:0]             slot;
  logic                         rd_valid;
  pofc_pkg::entry_t             rd_data;
  pofc_pkg::entry_t             wr_data;
  logic [pofc_pkg::STAMP_W-1:0] next_stamp;
  logic                         have;
  logic [pofc_pkg::PAGE_W-1:0]  best_page;
  logic [pofc_pkg::OFF_W-1:0]   best_offset;
  logic                         res_load;
  logic                         res_lookup;
  logic                         out_free;
  logic                         res_hit;

  assign out_free = !out_valid || out_ready;
  assign res_hit  = res_lookup && have;

  always_comb begin
    wr_data.hash   = op_hash;
    wr_data.page   = op_page;
    wr_data.offset = op_offset;
    wr_data.stamp  = next_stamp;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_hash   <= path_hash;
      op_page   <= page_number;
      op_offset <= byte_offset;
    end
  end

  pofc_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_kind    (kind),
    .in_ready   (in_ready),
    .out_free   (out_free),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .ent_idx    (ent_idx),
    .cmp_ctl    (cmp_ctl),
    .res_load   (res_load),
    .res_lookup (res_lookup),
    .next_stamp (next_stamp)
  );

  pofc_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (slot),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  pofc_cmp #(.ENTRIES(ENTRIES)) u_cmp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (cmp_ctl),
    .ent_valid   (rd_valid),
    .ent         (rd_data),
    .ent_idx     (ent_idx),
    .key_hash    (op_hash),
    .key_page    (op_page),
    .have        (have),
    .best_page   (best_page),
    .best_offset (best_offset),
    .slot        (slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      hit          <= res_hit;
      found_page   <= res_hit ? best_page : '0;
      found_offset <= res_hit ? best_offset : '0;
    end
  end

endmodule

@@ src/pofc_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pofc_mem
// Entry storage: one write port, one registered read port, valid flops.
// ----------------------------------------------------------------------------
module pofc_mem #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pofc_pkg::mem_ctl_t           ctl,
  input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
  input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
  input  pofc_pkg::entry_t             wr_data,
  output logic                         rd_valid,
  output pofc_pkg::entry_t             rd_data
);

  logic [ENTRIES-1:0] valid;
  pofc_pkg::entry_t   mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

@@ src/pofc_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pofc_cmp
// Shared compare unit: folds one entry per step into the running best
// (floor search for lookup, reuse/oldest victim search for store).
// ----------------------------------------------------------------------------
module pofc_cmp #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pofc_pkg::cmp_ctl_t                ctl,
  input  logic                              ent_valid,
  input  pofc_pkg::entry_t                  ent,
  input  logic [$clog2(ENTRIES)-1:0]        ent_idx,
  input  logic [pofc_pkg::HASH_W-1:0]       key_hash,
  input  logic [pofc_pkg::PAGE_W-1:0]       key_page,
  output logic                              have,
  output logic [pofc_pkg::PAGE_W-1:0]       best_page,
  output logic [pofc_pkg::OFF_W-1:0]        best_offset,
  output logic [$clog2(ENTRIES)-1:0]        slot
);

  logic                         direct;
  logic [pofc_pkg::STAMP_W-1:0] best_stamp;
  logic                         key_match;
  logic                         stamp_gt;
  logic                         stamp_lt;
  logic                         lk_take;
  logic                         st_direct;
  logic                         st_older;

  always_comb begin
    key_match = (ent.hash == key_hash);
    stamp_gt  = (ent.stamp > best_stamp);
    stamp_lt  = (ent.stamp < best_stamp);
    lk_take   = ent_valid && key_match && (ent.page <= key_page) &&
                (!have || (ent.page > best_page) ||
                 ((ent.page == best_page) && stamp_gt));
    st_direct = !ent_valid || (key_match && (ent.page == key_page));
    // have doubles as "first entry seen" during a store scan
    st_older  = !have || stamp_lt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have   <= 1'b0;
      direct <= 1'b0;
    end else if (ctl.init) begin
      have   <= 1'b0;
      direct <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.is_store) begin
        if (!direct && (st_direct || st_older)) begin
          have <= 1'b1;
        end
        if (!direct && st_direct) begin
          direct <= 1'b1;
        end
      end else if (lk_take) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (ctl.is_store) begin
        if (!direct && st_direct) begin
          slot <= ent_idx;
        end else if (!direct && st_older) begin
          slot       <= ent_idx;
          best_stamp <= ent.stamp;
        end
      end else if (lk_take) begin
        best_page   <= ent.page;
        best_offset <= ent.offset;
        best_stamp  <= ent.stamp;
      end
    end
  end

endmodule

@@ src/pofc_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pofc_seq
// Sequencer: accepts an operation, sweeps the table one entry per cycle,
// commits a store, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pofc_seq #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [pofc_pkg::KIND_W-1:0]       in_kind,
  output logic                              in_ready,
  input  logic                              out_free,
  output pofc_pkg::mem_ctl_t                mem_ctl,
  output logic [$clog2(ENTRIES)-1:0]        rd_addr,
  output logic [$clog2(ENTRIES)-1:0]        ent_idx,
  output pofc_pkg::cmp_ctl_t                cmp_ctl,
  output logic                              res_load,
  output logic                              res_lookup,
  output logic [pofc_pkg::STAMP_W-1:0]      next_stamp
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  pofc_pkg::state_t            state;
  pofc_pkg::state_t            state_next;
  logic [CNT_W-1:0]            cnt;
  logic [pofc_pkg::KIND_W-1:0] kind_q;
  logic                        step_q;
  logic                        accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    mem_ctl          = '0;
    cmp_ctl.init     = 1'b0;
    cmp_ctl.step     = step_q;
    cmp_ctl.is_store = (kind_q == pofc_pkg::KIND_STORE);
    rd_addr          = cnt[IDX_W-1:0];
    res_load         = 1'b0;
    res_lookup       = (kind_q == pofc_pkg::KIND_LOOKUP);
    unique case (state)
      pofc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmp_ctl.init = 1'b1;
          if (in_kind == pofc_pkg::KIND_LOOKUP || in_kind == pofc_pkg::KIND_STORE) begin
            state_next = pofc_pkg::ST_SCAN;
          end else begin
            mem_ctl.clear = (in_kind == pofc_pkg::KIND_CLEAR);
            state_next    = pofc_pkg::ST_RESP;
          end
        end
      end
      pofc_pkg::ST_SCAN: begin
        mem_ctl.rd_en = 1'b1;
        if (cnt == CNT_W'(ENTRIES - 1)) begin
          state_next = pofc_pkg::ST_LAST;
        end
      end
      pofc_pkg::ST_LAST: begin
        // last read data is folded in this cycle
        state_next = cmp_ctl.is_store ? pofc_pkg::ST_WRITE : pofc_pkg::ST_RESP;
      end
      pofc_pkg::ST_WRITE: begin
        mem_ctl.wr_en = 1'b1;
        state_next    = pofc_pkg::ST_RESP;
      end
      pofc_pkg::ST_RESP: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = pofc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pofc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pofc_pkg::ST_IDLE;
      step_q     <= 1'b0;
      next_stamp <= pofc_pkg::STAMP_FIRST;
    end else begin
      state  <= state_next;
      step_q <= mem_ctl.rd_en;
      if (mem_ctl.clear) begin
        next_stamp <= pofc_pkg::STAMP_FIRST;
      end else if (mem_ctl.wr_en) begin
        // counter skips 0 on wrap
        next_stamp <= (next_stamp == pofc_pkg::STAMP_LAST) ?
                      pofc_pkg::STAMP_FIRST : next_stamp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= in_kind;
      cnt    <= '0;
    end else if (mem_ctl.rd_en) begin
      cnt <= cnt + 1'b1;
    end
    ent_idx <= rd_addr;
  end

  a_stamp_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_stamp != '0)
    else $error("stamp counter reached zero");

  a_step_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_ctl.step |-> (state == pofc_pkg::ST_SCAN || state == pofc_pkg::ST_LAST))
    else $error("compare step outside of scan");

  a_write_only_store: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> (kind_q == pofc_pkg::KIND_STORE))
    else $error("table write for an operation other than store");

  a_lookup_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && in_kind == pofc_pkg::KIND_LOOKUP) |=> (state == pofc_pkg::ST_SCAN && cnt == '0))
    else $error("lookup did not start a scan at entry zero");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for page_offset_floor_cache. A queue of operations
// feeds a bursty driver. An in-bench copy of the table predicts the
// acknowledge of every accepted transaction. A monitor with its own stall
// pattern checks each result, in order, against those predictions.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ENTRIES = 16;
  localparam logic [pofc_pkg::KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int N_RANDOM = 500;
  localparam int MAX_PRINT = 100;

  typedef struct {
    logic [pofc_pkg::KIND_W-1:0] kind;
    logic [pofc_pkg::HASH_W-1:0] hash;
    logic [pofc_pkg::PAGE_W-1:0] page;
    logic [pofc_pkg::OFF_W-1:0]  offset;
    bit                          drain;   // wait for all acks before sending
  } op_t;

  typedef struct {
    logic                        hit;
    logic [pofc_pkg::PAGE_W-1:0] page;
    logic [pofc_pkg::OFF_W-1:0]  offset;
  } ack_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [pofc_pkg::KIND_W-1:0] kind = pofc_pkg::KIND_LOOKUP;
  logic [pofc_pkg::HASH_W-1:0] path_hash = '0;
  logic [pofc_pkg::PAGE_W-1:0] page_number = '0;
  logic [pofc_pkg::OFF_W-1:0]  byte_offset = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        hit;
  logic [pofc_pkg::PAGE_W-1:0] found_page;
  logic [pofc_pkg::OFF_W-1:0]  found_offset;

  page_offset_floor_cache #(.ENTRIES(ENTRIES)) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .path_hash   (path_hash),
    .page_number (page_number),
    .byte_offset (byte_offset),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .found_page  (found_page),
    .found_offset(found_offset)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // shadow copy of the table
  logic                         tbl_valid  [ENTRIES];
  logic [pofc_pkg::HASH_W-1:0]  tbl_hash   [ENTRIES];
  logic [pofc_pkg::PAGE_W-1:0]  tbl_page   [ENTRIES];
  logic [pofc_pkg::OFF_W-1:0]   tbl_offset [ENTRIES];
  logic [pofc_pkg::STAMP_W-1:0] tbl_stamp  [ENTRIES];
  logic [pofc_pkg::STAMP_W-1:0] stamp_next;

  op_t  pending_ops[$];
  ack_t ack_q[$];
  int   mismatches = 0;

  task automatic clear_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_hash[i]   = '0;
      tbl_page[i]   = '0;
      tbl_offset[i] = '0;
      tbl_stamp[i]  = '0;
    end
    stamp_next = pofc_pkg::STAMP_FIRST;
  endtask

  // apply one operation to the shadow table and return its acknowledge
  task automatic apply_op(input op_t op, output ack_t ack);
    logic                         have;
    logic [pofc_pkg::PAGE_W-1:0]  best_page;
    logic [pofc_pkg::OFF_W-1:0]   best_off;
    logic [pofc_pkg::STAMP_W-1:0] best_stamp;
    logic                         taken;
    int                           slot;
    logic [pofc_pkg::STAMP_W-1:0] oldest;
    ack.hit = 1'b0;
    ack.page = '0;
    ack.offset = '0;
    if (op.kind == pofc_pkg::KIND_LOOKUP) begin
      have = 1'b0;
      best_page = '0;
      best_off = '0;
      best_stamp = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_hash[i] == op.hash && tbl_page[i] <= op.page) begin
          if (!have || tbl_page[i] > best_page ||
              (tbl_page[i] == best_page && tbl_stamp[i] > best_stamp)) begin
            have = 1'b1;
            best_page = tbl_page[i];
            best_off = tbl_offset[i];
            best_stamp = tbl_stamp[i];
          end
        end
      end
      if (have) begin
        ack.hit = 1'b1;
        ack.page = best_page;
        ack.offset = best_off;
      end
    end else if (op.kind == pofc_pkg::KIND_STORE) begin
      // first empty or same hash/page entry, else first oldest stamp
      taken = 1'b0;
      slot = 0;
      oldest = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!taken) begin
          if (!tbl_valid[i] || (tbl_hash[i] == op.hash && tbl_page[i] == op.page)) begin
            slot = i;
            taken = 1'b1;
          end else if (i == 0 || tbl_stamp[i] < oldest) begin
            oldest = tbl_stamp[i];
            slot = i;
          end
        end
      end
      tbl_valid[slot]  = 1'b1;
      tbl_hash[slot]   = op.hash;
      tbl_page[slot]   = op.page;
      tbl_offset[slot] = op.offset;
      tbl_stamp[slot]  = stamp_next;
      stamp_next = stamp_next + 1'b1;
      if (stamp_next == '0) stamp_next = pofc_pkg::STAMP_FIRST;
    end else if (op.kind == pofc_pkg::KIND_CLEAR) begin
      clear_shadow();
    end
  endtask

  task automatic queue_op(input logic [pofc_pkg::KIND_W-1:0] k,
                          input logic [pofc_pkg::HASH_W-1:0] h,
                          input logic [pofc_pkg::PAGE_W-1:0] p,
                          input logic [pofc_pkg::OFF_W-1:0] o,
                          input bit drain);
    op_t op;
    op.kind = k;
    op.hash = h;
    op.page = p;
    op.offset = o;
    op.drain = drain;
    pending_ops.push_back(op);
  endtask

  task automatic report(input string msg);
    if (mismatches < MAX_PRINT) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // driver: bursts of transactions separated by random gaps
  op_t  cur_op;
  ack_t pred_ack;
  int   burst_left = 4;
  int   gap_left = 0;
  bit   send;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_op(cur_op, pred_ack);
        ack_q.push_back(pred_ack);
      end
      if (!in_valid || in_ready) begin
        send = 1'b0;
        if (gap_left > 0) gap_left--;
        else if (pending_ops.size() > 0 && !(pending_ops[0].drain && ack_q.size() != 0))
          send = 1'b1;
        if (send) begin
          cur_op = pending_ops.pop_front();
          kind        <= cur_op.kind;
          path_hash   <= cur_op.hash;
          page_number <= cur_op.page;
          byte_offset <= cur_op.offset;
          in_valid    <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives out_ready on a mode-switching pattern
  ack_t exp_ack;
  int   stall_mode = 0;
  int   mode_left = 50;
  int   hold_left = 0;
  logic rdy_next;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (ack_q.size() == 0) begin
        report($sformatf("result with nothing pending hit=%0d page=%0d off=%h",
                         hit, found_page, found_offset));
      end else begin
        exp_ack = ack_q.pop_front();
        if (hit !== exp_ack.hit)
          report($sformatf("hit got %0d exp %0d", hit, exp_ack.hit));
        if (found_page !== exp_ack.page)
          report($sformatf("found_page got %0d exp %0d", found_page, exp_ack.page));
        if (found_offset !== exp_ack.offset)
          report($sformatf("found_offset got %h exp %h", found_offset, exp_ack.offset));
      end
    end
    if (mode_left <= 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      rdy_next = 1'b0;
    end else begin
      case (stall_mode)
        0: rdy_next = 1'b1;
        1: rdy_next = ($urandom_range(0, 3) != 0);
        default: begin
          rdy_next = 1'b1;
          if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(5, 30);
        end
      endcase
    end
    out_ready <= rdy_next;
  end

  initial begin
    logic [pofc_pkg::HASH_W-1:0] pool[4];
    logic [pofc_pkg::HASH_W-1:0] h;
    logic [pofc_pkg::PAGE_W-1:0] p;
    int sel;

    clear_shadow();

    // directed part
    // empty table miss
    queue_op(pofc_pkg::KIND_LOOKUP, 32'h0, 16'h0, 32'h0, 0);
    queue_op(pofc_pkg::KIND_STORE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    // exact hit, then page above target
    queue_op(pofc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 0);
    queue_op(pofc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'hFFFE, 32'h0, 0);
    queue_op(pofc_pkg::KIND_STORE, 32'h0, 16'h0, 32'h0, 0);
    // floor at page 0, other hash misses
    queue_op(pofc_pkg::KIND_LOOKUP, 32'h0, 16'hFFFF, 32'h0, 0);
    queue_op(pofc_pkg::KIND_LOOKUP, 32'h1, 16'hFFFF, 32'h0, 0);
    queue_op(pofc_pkg::KIND_STORE, 32'hA5A5_5A5A, 16'd10, 32'h1111_0000, 0);
    // same hash+page reuse
    queue_op(pofc_pkg::KIND_STORE, 32'hA5A5_5A5A, 16'd10, 32'h2222_0000, 0);
    queue_op(pofc_pkg::KIND_STORE, 32'hA5A5_5A5A, 16'd20, 32'h3333_0000, 0);
    queue_op(pofc_pkg::KIND_LOOKUP, 32'hA5A5_5A5A, 16'd15, 32'hDEAD_BEEF, 0);
    queue_op(pofc_pkg::KIND_LOOKUP, 32'hA5A5_5A5A, 16'd25, 32'h0, 0);
    queue_op(pofc_pkg::KIND_LOOKUP, 32'hA5A5_5A5A, 16'd9, 32'h0, 0);
    // unused kind
    queue_op(KIND_NOP, 32'h5A5A_A5A5, 16'hFFFF, 32'hFFFF_FFFF, 0);
    // sent after drain
    queue_op(pofc_pkg::KIND_LOOKUP, 32'hA5A5_5A5A, 16'd20, 32'h0, 1);
    queue_op(pofc_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    // miss after clear
    queue_op(pofc_pkg::KIND_LOOKUP, 32'hA5A5_5A5A, 16'd25, 32'h0, 0);
    queue_op(pofc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 0);
    queue_op(pofc_pkg::KIND_STORE, 32'h0, 16'hFFFF, 32'h8000_0001, 0);
    queue_op(pofc_pkg::KIND_LOOKUP, 32'h0, 16'hFFFF, 32'h0, 0);
    queue_op(pofc_pkg::KIND_CLEAR, 32'h0, 16'h0, 32'h0, 1);

    // random part: a few documents, dense page numbers so the table fills
    // and replacement is exercised; occasional clears, nops and noise
    pool[0] = 32'h0;
    pool[1] = 32'hFFFF_FFFF;
    pool[2] = $urandom;
    pool[3] = $urandom;
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 99) < 3) pool[$urandom_range(2, 3)] = $urandom;
      h = pool[$urandom_range(0, 3)];
      p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
      sel = $urandom_range(0, 99);
      if (sel < 45)
        queue_op(pofc_pkg::KIND_LOOKUP, h, p, $urandom, ($urandom_range(0, 49) == 0));
      else if (sel < 90)
        queue_op(pofc_pkg::KIND_STORE, h, p, $urandom, ($urandom_range(0, 49) == 0));
      else if (sel < 93)
        queue_op(pofc_pkg::KIND_CLEAR, $urandom, 16'($urandom), $urandom, 0);
      else if (sel < 96)
        queue_op(KIND_NOP, $urandom, 16'($urandom), $urandom, 0);
      else
        queue_op(pofc_pkg::KIND_W'($urandom_range(0, 1)), $urandom, 16'($urandom),
                 $urandom, 0);
    end

    while (pending_ops.size() != 0 || in_valid || ack_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(64'd5_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
